@@ rtl/vrs_pkg.sv @@
package vrs_pkg;

	// Store geometry and record limits.
	localparam int STACK_BYTES  = 1024;
	localparam int MAX_RECORD   = 64;
	localparam int HEADER_BYTES = 4;

	localparam int ADDR_W    = $clog2(STACK_BYTES);
	localparam int TOP_W     = $clog2(STACK_BYTES + 1);
	localparam int SUM_W     = TOP_W + 9;
	localparam int CNT_W     = $clog2(MAX_RECORD + 1);
	localparam int HDR_CNT_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

	// Field widths fixed by the stream format.
	localparam int LEN_W  = 7;
	localparam int FREE_W = 11;
	localparam int IN_W   = 24;
	localparam int OUT_W  = 24;

	// Command queue between the front and the back. Depth is a power of two.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_PEEK  = 2'd2,
		OP_CLEAR = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		K_PUSH_FIRST,
		K_PUSH_NEXT,
		K_POP,
		K_PEEK,
		K_CLEAR
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [7:0]        data_byte;
		logic [LEN_W-1:0]  length;
	} cmd_t;

	typedef struct packed {
		status_t           status;
		logic [7:0]        data_byte;
		logic              has_data;
		logic              last;
		logic [FREE_W-1:0] free_bytes;
	} res_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_HDR,
		B_HWAIT,
		B_STREAM,
		B_RESULT
	} bstate_t;

endpackage

@@ rtl/vrs_ram.sv @@
module vrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read data holds its value until the next read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/vrs_front.sv @@
module vrs_front import vrs_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  logic [IN_W-1:0] s_axis_tdata,
	input  logic            q_full,
	output logic            q_push,
	output cmd_t            q_cmd
);

	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] rem_d;
	opcode_t          op;
	logic [7:0]       data_byte;
	logic [LEN_W-1:0] length;

	assign op        = opcode_t'(s_axis_tdata[1:0]);
	assign data_byte = s_axis_tdata[9:2];
	assign length    = s_axis_tdata[16:10];

	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && !q_full;

	// A push beat opens a record when no bytes are outstanding; any other
	// operation ends an unfinished push.
	always_comb begin
		q_cmd.data_byte = data_byte;
		q_cmd.length    = length;
		rem_d           = '0;
		case (op)
			OP_PUSH: begin
				if (rem_q == '0) begin
					q_cmd.kind = K_PUSH_FIRST;
					rem_d      = (length != '0) ? length - 1'b1 : '0;
				end else begin
					q_cmd.kind = K_PUSH_NEXT;
					rem_d      = rem_q - 1'b1;
				end
			end
			OP_POP:   q_cmd.kind = K_POP;
			OP_PEEK:  q_cmd.kind = K_PEEK;
			OP_CLEAR: q_cmd.kind = K_CLEAR;
			default:  q_cmd.kind = K_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (q_push) begin
			rem_q <= rem_d;
		end
	end

endmodule

@@ rtl/vrs_queue.sv @@
module vrs_queue import vrs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic empty
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/vrs_back.sv @@
module vrs_back import vrs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  cmd_t              q_cmd,
	output logic              q_pop,
	output logic              ram_wr_en,
	output logic [ADDR_W-1:0] ram_wr_addr,
	output logic [7:0]        ram_wr_data,
	output logic              ram_rd_en,
	output logic [ADDR_W-1:0] ram_rd_addr,
	input  logic [7:0]        ram_rd_data,
	output logic              out_valid,
	input  logic              out_ready,
	output res_t              out_res
);

	bstate_t              state_q, state_d;
	cmd_t                 cur_q, cur_d;
	status_t              status_q, status_d;
	logic [TOP_W-1:0]     top_q, top_d;
	logic [ADDR_W-1:0]    paddr_q, paddr_d;
	logic [ADDR_W-1:0]    base_q, base_d;
	logic                 rej_q, rej_d;
	logic [HDR_CNT_W-1:0] hcnt_q, hcnt_d;
	logic [CNT_W-1:0]     n_q, n_d;
	logic [CNT_W-1:0]     iss_q, iss_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic                 pend_q, pend_d;
	logic                 out_valid_q, out_valid_d;
	res_t                 res_q, res_d;

	logic                 out_free;
	logic [TOP_W:0]       need;
	logic                 rej_c;
	logic [7:0]           hdr_min;
	logic [SUM_W-1:0]     pop_top;
	logic                 move;
	logic                 issue;
	logic                 last_c;
	logic                 store_byte;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	assign need    = (TOP_W+1)'(HEADER_BYTES) + (TOP_W+1)'(q_cmd.length);
	assign rej_c   = (q_cmd.length > LEN_W'(MAX_RECORD)) || (need > {1'b0, top_q});
	assign hdr_min = (ram_rd_data < {1'b0, cur_q.length}) ? ram_rd_data : {1'b0, cur_q.length};
	assign pop_top = SUM_W'(top_q) + SUM_W'(HEADER_BYTES) + SUM_W'(ram_rd_data);

	assign move   = pend_q && out_free;
	assign last_c = (CNT_W'(cnt_q + 1'b1) == n_q);
	assign issue  = (iss_q != n_q) && (!pend_q || move);

	assign store_byte = !rej_q && ((cur_q.kind == K_PUSH_NEXT) ||
		((cur_q.kind == K_PUSH_FIRST) && (cur_q.length != '0)));

	always_comb begin
		state_d     = state_q;
		cur_d       = cur_q;
		status_d    = status_q;
		top_d       = top_q;
		paddr_d     = paddr_q;
		base_d      = base_q;
		rej_d       = rej_q;
		hcnt_d      = hcnt_q;
		n_d         = n_q;
		iss_d       = iss_q;
		cnt_d       = cnt_q;
		pend_d      = pend_q;
		out_valid_d = out_valid_q && !out_ready;
		res_d       = res_q;
		q_pop       = 1'b0;
		ram_wr_en   = 1'b0;
		ram_wr_addr = paddr_q;
		ram_wr_data = cur_q.data_byte;
		ram_rd_en   = 1'b0;
		ram_rd_addr = top_q[ADDR_W-1:0];

		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					cur_d = q_cmd;
					case (q_cmd.kind)
						K_PUSH_FIRST: begin
							rej_d = rej_c;
							if (rej_c) begin
								status_d = ST_FULL;
								state_d  = B_RESULT;
							end else begin
								status_d = ST_OK;
								top_d    = top_q - need[TOP_W-1:0];
								paddr_d  = ADDR_W'(top_q - need[TOP_W-1:0]);
								hcnt_d   = '0;
								state_d  = B_HDR;
							end
						end
						K_PUSH_NEXT: begin
							status_d = rej_q ? ST_FULL : ST_OK;
							state_d  = B_RESULT;
						end
						K_CLEAR: begin
							rej_d    = 1'b0;
							top_d    = TOP_W'(STACK_BYTES);
							status_d = ST_OK;
							state_d  = B_RESULT;
						end
						K_POP, K_PEEK: begin
							rej_d = 1'b0;
							if (top_q == TOP_W'(STACK_BYTES)) begin
								status_d = ST_EMPTY;
								state_d  = B_RESULT;
							end else begin
								ram_rd_en   = 1'b1;
								ram_rd_addr = top_q[ADDR_W-1:0];
								state_d     = B_HWAIT;
							end
						end
						default: begin
							state_d = B_IDLE;
						end
					endcase
				end
			end

			B_HDR: begin
				// Lengths fit one byte, so only the lowest header byte is nonzero.
				ram_wr_en   = 1'b1;
				ram_wr_addr = paddr_q + ADDR_W'(hcnt_q);
				ram_wr_data = (hcnt_q == '0) ? 8'(cur_q.length) : 8'd0;
				if (hcnt_q == HDR_CNT_W'(HEADER_BYTES - 1)) begin
					paddr_d = paddr_q + ADDR_W'(HEADER_BYTES);
					state_d = B_RESULT;
				end else begin
					hcnt_d = hcnt_q + 1'b1;
				end
			end

			B_HWAIT: begin
				// The header's low byte is on the read port now.
				n_d    = (hdr_min > 8'(MAX_RECORD)) ? CNT_W'(MAX_RECORD) : CNT_W'(hdr_min);
				base_d = ADDR_W'(top_q + TOP_W'(HEADER_BYTES));
				if (cur_q.kind == K_POP) begin
					top_d = (pop_top > SUM_W'(STACK_BYTES)) ? TOP_W'(STACK_BYTES)
						: pop_top[TOP_W-1:0];
				end
				if (hdr_min == '0) begin
					status_d = ST_OK;
					state_d  = B_RESULT;
				end else begin
					iss_d   = '0;
					cnt_d   = '0;
					pend_d  = 1'b0;
					state_d = B_STREAM;
				end
			end

			B_STREAM: begin
				if (move) begin
					out_valid_d      = 1'b1;
					res_d.status     = ST_OK;
					res_d.data_byte  = ram_rd_data;
					res_d.has_data   = 1'b1;
					res_d.last       = last_c;
					res_d.free_bytes = FREE_W'(top_q);
					cnt_d            = cnt_q + 1'b1;
					if (last_c) begin
						state_d = B_IDLE;
					end
				end
				if (issue) begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = base_q + ADDR_W'(iss_q);
					iss_d       = iss_q + 1'b1;
				end
				pend_d = issue || (pend_q && !move);
			end

			B_RESULT: begin
				if (out_free) begin
					out_valid_d      = 1'b1;
					res_d.status     = status_q;
					res_d.data_byte  = 8'd0;
					res_d.has_data   = 1'b0;
					res_d.last       = 1'b1;
					res_d.free_bytes = FREE_W'(top_q);
					if (store_byte) begin
						ram_wr_en   = 1'b1;
						ram_wr_addr = paddr_q;
						ram_wr_data = cur_q.data_byte;
						paddr_d     = paddr_q + 1'b1;
					end
					state_d = B_IDLE;
				end
			end

			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			top_q       <= TOP_W'(STACK_BYTES);
			paddr_q     <= '0;
			rej_q       <= 1'b0;
			hcnt_q      <= '0;
			n_q         <= '0;
			iss_q       <= '0;
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			top_q       <= top_d;
			paddr_q     <= paddr_d;
			rej_q       <= rej_d;
			hcnt_q      <= hcnt_d;
			n_q         <= n_d;
			iss_q       <= iss_d;
			cnt_q       <= cnt_d;
			pend_q      <= pend_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q    <= cur_d;
		status_q <= status_d;
		base_q   <= base_d;
		res_q    <= res_d;
	end

	// The store has one write and one read per cycle, never both at once here.
	a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_wr_en && ram_rd_en))
		else $error("store written and read in the same cycle");

	a_top_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= TOP_W'(STACK_BYTES))
		else $error("top offset beyond the store");

	a_stream_counts: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_STREAM |-> (cnt_q <= iss_q) && (iss_q <= n_q))
		else $error("stream emitted more bytes than it read");

	a_stream_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_STREAM && move && last_c) |=> (state_q == B_IDLE) && out_valid_q)
		else $error("stream did not close after its last byte");

endmodule

@@ rtl/variable_record_stack.sv @@
// A push beat's response is registered: the back takes the request from the queue in
// B_IDLE and answers from B_RESULT, and the first beat of a record writes the header in B_HDR first.
// The back handles one request at a time and takes no new push beat until it has answered the last;
// the first popped or peeked byte follows the header read in B_HWAIT and a byte read in B_STREAM,
// and later bytes follow one per cycle while the output is ready.
// Reset clears the control state and empties the stack; record store contents
// stay undefined and need no clearing pass.
module variable_record_stack import vrs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,   // opcode[1:0], data_byte[9:2], length[16:10]
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata,   // status[1:0], data_byte_res[9:2], free_bytes[20:10]
	output logic             m_axis_tlast,
	output logic             m_axis_tuser    // has_data
);

	// Every request is classified by the front (which beat of a push it is, or
	// which stack operation) and queued; the back owns the top offset and the
	// byte store and performs the operation. The queue lets the input side keep
	// taking requests while the back streams bytes out or waits on the output.

	logic              q_full;
	logic              q_empty;
	logic              q_push;
	logic              q_pop;
	cmd_t              front_cmd;
	cmd_t              back_cmd;
	logic              ram_wr_en;
	logic [ADDR_W-1:0] ram_wr_addr;
	logic [7:0]        ram_wr_data;
	logic              ram_rd_en;
	logic [ADDR_W-1:0] ram_rd_addr;
	logic [7:0]        ram_rd_data;
	res_t              res;

	vrs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_cmd         (front_cmd)
	);

	vrs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (front_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (back_cmd),
		.empty    (q_empty)
	);

	vrs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_cmd       (back_cmd),
		.q_pop       (q_pop),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.ram_rd_en   (ram_rd_en),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_res     (res)
	);

	// The record store: headers sit below their record bytes, and the stack
	// grows toward address zero.
	vrs_ram #(
		.WIDTH (8),
		.DEPTH (STACK_BYTES)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Pack the result fields; the upper pad bits are zero.
	assign m_axis_tdata = {3'b000, res.free_bytes, res.data_byte, res.status};
	assign m_axis_tlast = res.last;
	assign m_axis_tuser = res.has_data;

endmodule

@@ bench/testbench.sv @@
module testbench import vrs_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// Clock and reset. Reset is held at the start and never again.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	// Stream signals. Every input of the block has a known value from time zero.
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic             m_axis_tlast;
	logic             m_axis_tuser;

	variable_record_stack u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	// One row of the directed table. A row with several beats sends the same
	// request repeatedly with the data byte stepped by an odd amount, so each beat
	// of a long push row carries a distinct byte value. Rows marked pinned carry their
	// expected single response directly; the rest are left to the stack model.
	typedef struct {
		opcode_t    op;
		logic [7:0] data;
		logic [6:0] len;
		int         beats;
		bit         pinned;
		status_t    st;
		int         free_cnt;
	} stim_row_t;

	localparam int NUM_ROWS = 25;
	localparam int RAND_ITEMS = 49;
	stim_row_t stim_rows [NUM_ROWS];

	// Stack model state: its own byte store, a map of which bytes were ever
	// written since reset, the top offset and the progress of a push in flight.
	logic [7:0] model_mem [STACK_BYTES];
	bit         mem_written [STACK_BYTES];
	int         top_ptr = STACK_BYTES;
	int         beats_left = 0;
	int         wr_addr = 0;
	bit         refused = 1'b0;

	// Responses still owed by the block, oldest first.
	res_t pending_results [$];

	// Pinned expectation of the request currently on the bus.
	bit      pin_now = 1'b0;
	status_t pin_status = ST_OK;
	int      pin_free = 0;

	// When set, neither side idles.
	bit calm = 1'b0;

	// Bookkeeping for the verdict and the summary.
	int fault_count = 0;
	int requests_taken = 0;
	int results_checked = 0;
	int bytes_streamed = 0;
	int full_seen = 0;
	int empty_seen = 0;

	function automatic void mem_put(input int addr, input logic [7:0] v);
		if (addr >= 0 && addr < STACK_BYTES) begin
			model_mem[addr] = v;
			mem_written[addr] = 1'b1;
		end
	endfunction

	function automatic logic [7:0] mem_get(input int addr);
		if (addr >= 0 && addr < STACK_BYTES) begin
			return model_mem[addr];
		end
		return 8'h00;
	endfunction

	// Advance the stack model by one accepted request and queue the responses
	// it owes. Every response reports the top offset after the operation.
	task automatic stack_step(input opcode_t op, input logic [7:0] b, input logic [6:0] len);
		int need;
		int hdr;
		int n;
		int base;
		int i;
		logic [7:0] grabbed [MAX_RECORD];
		res_t r;
		r = '0;
		r.last = 1'b1;
		if (op == OP_PUSH) begin
			if (beats_left == 0) begin
				// First beat: the header goes in at once when the record fits.
				need = HEADER_BYTES + int'(len);
				refused = (int'(len) > MAX_RECORD) || (need > top_ptr);
				if (!refused) begin
					top_ptr -= need;
					for (i = 0; i < HEADER_BYTES; i++) begin
						mem_put(top_ptr + i, 8'((int'(len) >> (8 * i)) & 8'hFF));
					end
					wr_addr = top_ptr + HEADER_BYTES;
				end
				if (len > 0) begin
					if (!refused) begin
						mem_put(wr_addr, b);
						wr_addr++;
					end
					beats_left = int'(len) - 1;
				end
			end else begin
				if (!refused) begin
					mem_put(wr_addr, b);
					wr_addr++;
				end
				beats_left--;
			end
			r.status = refused ? ST_FULL : ST_OK;
			r.free_bytes = top_ptr[FREE_W-1:0];
			pending_results.push_back(r);
			if (beats_left == 0) begin
				refused = 1'b0;
			end
		end else begin
			// Any other request ends an unfinished push.
			beats_left = 0;
			refused = 1'b0;
			if (op == OP_CLEAR) begin
				top_ptr = STACK_BYTES;
				r.status = ST_OK;
				r.free_bytes = top_ptr[FREE_W-1:0];
				pending_results.push_back(r);
			end else if (top_ptr >= STACK_BYTES) begin
				r.status = ST_EMPTY;
				r.free_bytes = top_ptr[FREE_W-1:0];
				pending_results.push_back(r);
			end else begin
				base = top_ptr;
				hdr = 0;
				for (i = 0; i < HEADER_BYTES; i++) begin
					hdr |= int'(mem_get(base + i)) << (8 * i);
				end
				n = (hdr < int'(len)) ? hdr : int'(len);
				if (n > MAX_RECORD) begin
					n = MAX_RECORD;
				end
				for (i = 0; i < n; i++) begin
					grabbed[i] = mem_get(base + HEADER_BYTES + i);
				end
				// A pop frees the record, saturating at an empty stack.
				if (op == OP_POP) begin
					top_ptr = base + HEADER_BYTES + hdr;
					if (top_ptr > STACK_BYTES) begin
						top_ptr = STACK_BYTES;
					end
				end
				r.status = ST_OK;
				r.free_bytes = top_ptr[FREE_W-1:0];
				if (n == 0) begin
					pending_results.push_back(r);
				end else begin
					for (i = 0; i < n; i++) begin
						r.data_byte = grabbed[i];
						r.has_data = 1'b1;
						r.last = (i == n - 1);
						pending_results.push_back(r);
					end
				end
			end
		end
	endtask

	// Largest byte count that a pop or peek may request right now without
	// reading a store byte that was never written since reset. On an empty
	// stack nothing is read, so any request is fine.
	function automatic int safe_request(input int want);
		int hdr;
		int n;
		int i;
		if (top_ptr >= STACK_BYTES) begin
			return want;
		end
		hdr = 0;
		for (i = 0; i < HEADER_BYTES; i++) begin
			hdr |= int'(mem_get(top_ptr + i)) << (8 * i);
		end
		n = (hdr < want) ? hdr : want;
		if (n > MAX_RECORD) begin
			n = MAX_RECORD;
		end
		for (i = 0; i < n; i++) begin
			if (top_ptr + HEADER_BYTES + i >= STACK_BYTES ||
			    !mem_written[top_ptr + HEADER_BYTES + i]) begin
				return i;
			end
		end
		return want;
	endfunction

	// Compare one accepted response with the oldest expectation.
	task automatic check_result(input res_t got);
		res_t want;
		if (pending_results.size() == 0) begin
			fault_count++;
			if (fault_count <= 10) begin
				$display("unexpected response: status %0d byte %02h has %0b last %0b free %0d",
					got.status, got.data_byte, got.has_data, got.last, got.free_bytes);
			end
		end else begin
			want = pending_results.pop_front();
			results_checked++;
			if (want.has_data) bytes_streamed++;
			if (want.status == ST_FULL) full_seen++;
			if (want.status == ST_EMPTY) empty_seen++;
			if (got.status !== want.status || got.data_byte !== want.data_byte ||
			    got.has_data !== want.has_data || got.last !== want.last ||
			    got.free_bytes !== want.free_bytes) begin
				fault_count++;
				if (fault_count <= 10) begin
					$display("mismatch at response %0d: expected status %0d byte %02h",
						results_checked, want.status, want.data_byte);
					$display("    expected has %0b last %0b free %0d",
						want.has_data, want.last, want.free_bytes);
					$display("    got status %0d byte %02h has %0b last %0b free %0d",
						got.status, got.data_byte, got.has_data, got.last,
						got.free_bytes);
				end
			end
		end
	endtask

	// Everything is sampled at the rising edge. Responses are checked first,
	// then an accepted request is run through the model. A response can never
	// come back in the same cycle its request was taken, so the order is safe.
	always @(posedge clk) begin : scoreboard
		int depth;
		res_t got;
		res_t pinned_res;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = status_t'(m_axis_tdata[1:0]);
				got.data_byte = m_axis_tdata[9:2];
				got.free_bytes = m_axis_tdata[20:10];
				got.has_data = m_axis_tuser;
				got.last = m_axis_tlast;
				check_result(got);
			end
			if (s_axis_tvalid && s_axis_tready) begin
				requests_taken++;
				depth = pending_results.size();
				stack_step(opcode_t'(s_axis_tdata[1:0]), s_axis_tdata[9:2],
					s_axis_tdata[16:10]);
				// A pinned row replaces the model's answer with the table value,
				// while the model state still moves on.
				if (pin_now) begin
					while (pending_results.size() > depth) begin
						void'(pending_results.pop_back());
					end
					pinned_res = '0;
					pinned_res.status = pin_status;
					pinned_res.last = 1'b1;
					pinned_res.free_bytes = pin_free[FREE_W-1:0];
					pending_results.push_back(pinned_res);
				end
			end
		end
	end

	// The receiving side stalls at random with a chance of 37 in a hundred, except while calm.
	always @(negedge clk) begin
		m_axis_tready <= calm || ($urandom_range(0, 99) >= 37);
	end

	// Offer one request. Called at a falling edge; returns at the falling edge
	// after the request was accepted, by which time the model has seen it.
	// tvalid gets at most one assignment per falling edge.
	task automatic send_request(input opcode_t op, input logic [7:0] b, input logic [6:0] len,
	                            input bit pin, input status_t pst, input int pfree);
		bit offered;
		offered = 1'b0;
		while (!offered) begin
			if (!calm && $urandom_range(0, 99) < 37) begin
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {7'b0, len, b, op};
				pin_now = pin;
				pin_status = pst;
				pin_free = pfree;
				offered = 1'b1;
			end
		end
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Pop or peek with a request count that stays inside written store bytes.
	task automatic send_read(input opcode_t op, input int want);
		send_request(op, 8'($urandom_range(0, 255)), 7'(safe_request(want)), 1'b0, ST_OK, 0);
	endtask

	initial begin : stimulus
		int row;
		int beat;
		int rand_items;
		int pick;
		int rec_len;
		int part;
		int want;
		// Directed part: empty-stack reads, a zero-length record, zero-byte pop
		// and peek, filling the store to the last byte with one-byte records,
		// the refusals that follow, interrupted pushes, clears and a full-size
		// read of a record whose push was cut short after its first byte.
		stim_rows = '{
			'{OP_POP,   8'h00, 7'd64, 1,   1'b1, ST_EMPTY, 1024},
			'{OP_PEEK,  8'hFF, 7'd0,  1,   1'b1, ST_EMPTY, 1024},
			'{OP_CLEAR, 8'h00, 7'd0,  1,   1'b1, ST_OK,    1024},
			'{OP_PUSH,  8'hA5, 7'd0,  1,   1'b1, ST_OK,    1020},
			'{OP_PEEK,  8'h00, 7'd5,  1,   1'b1, ST_OK,    1020},
			'{OP_POP,   8'h00, 7'd5,  1,   1'b1, ST_OK,    1024},
			'{OP_PUSH,  8'hFF, 7'd1,  1,   1'b1, ST_OK,    1019},
			'{OP_PEEK,  8'h00, 7'd64, 1,   1'b0, ST_OK,    0},
			'{OP_POP,   8'h00, 7'd0,  1,   1'b1, ST_OK,    1024},
			'{OP_PUSH,  8'h00, 7'd1,  204, 1'b0, ST_OK,    0},
			'{OP_PEEK,  8'h00, 7'd64, 1,   1'b0, ST_OK,    0},
			'{OP_PUSH,  8'h5A, 7'd0,  1,   1'b1, ST_OK,    0},
			'{OP_PUSH,  8'h01, 7'd0,  1,   1'b1, ST_FULL,  0},
			'{OP_PUSH,  8'hFF, 7'd3,  3,   1'b1, ST_FULL,  0},
			'{OP_POP,   8'h00, 7'd64, 1,   1'b1, ST_OK,    4},
			'{OP_PUSH,  8'h00, 7'd1,  1,   1'b1, ST_FULL,  4},
			'{OP_POP,   8'h00, 7'd64, 1,   1'b0, ST_OK,    0},
			'{OP_CLEAR, 8'h00, 7'd0,  1,   1'b1, ST_OK,    1024},
			'{OP_PUSH,  8'h3C, 7'd2,  1,   1'b0, ST_OK,    0},
			'{OP_PEEK,  8'h00, 7'd2,  1,   1'b0, ST_OK,    0},
			'{OP_PUSH,  8'hC3, 7'd5,  2,   1'b0, ST_OK,    0},
			'{OP_POP,   8'h00, 7'd64, 1,   1'b0, ST_OK,    0},
			'{OP_PUSH,  8'h77, 7'd64, 1,   1'b0, ST_OK,    0},
			'{OP_PEEK,  8'h00, 7'd64, 1,   1'b0, ST_OK,    0},
			'{OP_POP,   8'h00, 7'd64, 1,   1'b0, ST_OK,    0}
		};

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (row = 0; row < NUM_ROWS; row++) begin
			for (beat = 0; beat < stim_rows[row].beats; beat++) begin
				send_request(stim_rows[row].op, 8'(stim_rows[row].data + 37 * beat),
					stim_rows[row].len, stim_rows[row].pinned, stim_rows[row].st,
					stim_rows[row].free_cnt);
			end
		end

		// Random part. Most of it is complete records with random bytes and
		// lengths (mostly short), mixed with pops, peeks, clears and pushes cut
		// short by a read. Record lengths are trimmed to the items left in the
		// budget. A stretch in the middle runs with no idling on either side.
		rand_items = 0;
		while (rand_items < RAND_ITEMS) begin
			calm = (rand_items >= 10 && rand_items < 36);
			pick = $urandom_range(0, 99);
			if (pick < 50 || pick >= 93) begin
				if (pick >= 93 || $urandom_range(0, 3) == 0) begin
					rec_len = $urandom_range(0, MAX_RECORD);
				end else begin
					rec_len = $urandom_range(0, 8);
				end
				if (rec_len > RAND_ITEMS - rand_items) begin
					rec_len = RAND_ITEMS - rand_items;
				end
				for (beat = 0; beat < ((rec_len > 0) ? rec_len : 1); beat++) begin
					// Later beats carry a random length that the block ignores.
					send_request(OP_PUSH, 8'($urandom_range(0, 255)),
						7'((beat == 0) ? rec_len : $urandom_range(0, MAX_RECORD)),
						1'b0, ST_OK, 0);
					rand_items++;
				end
			end else if (pick < 57) begin
				// Push cut short, then ended by a read of the same record.
				rec_len = $urandom_range(2, MAX_RECORD);
				part = $urandom_range(1, (rec_len > 8) ? 8 : rec_len - 1);
				for (beat = 0; beat < part; beat++) begin
					send_request(OP_PUSH, 8'($urandom_range(0, 255)), 7'(rec_len),
						1'b0, ST_OK, 0);
					rand_items++;
				end
				send_read($urandom_range(0, 1) ? OP_PEEK : OP_POP, MAX_RECORD);
				rand_items++;
			end else if (pick < 90) begin
				want = $urandom_range(0, 1) ? MAX_RECORD : $urandom_range(0, MAX_RECORD);
				send_read((pick < 72) ? OP_POP : OP_PEEK, want);
				rand_items++;
			end else begin
				send_request(OP_CLEAR, 8'($urandom_range(0, 255)),
					7'($urandom_range(0, MAX_RECORD)), 1'b0, ST_OK, 0);
				rand_items++;
			end
		end
		calm = 1'b0;
		s_axis_tvalid <= 1'b0;

		// Drain: wait for every owed response, then keep the clock running to catch
		// anything extra the block might still send.
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (pending_results.size() != 0) begin
			fault_count++;
		end

		$display("summary: %0d requests taken, %0d responses checked, %0d record bytes streamed",
			requests_taken, results_checked, bytes_streamed);
		$display("summary: %0d no-room responses, %0d empty-stack responses, %0d faults",
			full_seen, empty_seen, fault_count);
		if (fault_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#5000000;
		$display("tb: failure");
		$finish;
	end

endmodule
